// ===== sv/wdpf_pkg.sv =====
// ----------------------------------------------------------------------------
// wdpf_pkg
// Shared types, constants and table functions for the wall distance fix.
// ----------------------------------------------------------------------------
`default_nettype none

package wdpf_pkg;

    localparam int IN_DATA_W   = 96;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 56;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int MM_W        = 14;
    localparam int SPAN_W      = 15;
    localparam int TERM_W      = 36;
    localparam int SC_W        = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALID = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALID = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WALL_SPAN = 2'd2;

    localparam logic [MM_W-1:0]   MIN_VALID_RST = 14'd0;
    localparam logic [MM_W-1:0]   MAX_VALID_RST = 14'd16383;
    localparam logic [SPAN_W-1:0] WALL_SPAN_RST = 15'd18432;

    // floor(q / 127) == (q * RECIP_127) >> 32 for q below 2^25
    localparam logic [25:0] RECIP_127 = 26'd33818641;
    // floor(w / 3) == (w * RECIP_3) >> 24 for w below 2^23
    localparam logic [22:0] RECIP_3   = 23'd5592406;
    localparam logic [22:0] DIV3_BIAS = 23'd3145728;

    // mounting offsets, 1/256 in
    localparam int LEFT_OX  = -896;
    localparam int LEFT_OY  = 1472;
    localparam int RIGHT_OX = 896;
    localparam int RIGHT_OY = 1472;
    localparam int BACK_OX  = 1382;
    localparam int BACK_OY  = -384;

    typedef enum logic [1:0] {
        BEAM_LEFT  = 2'd0,
        BEAM_RIGHT = 2'd1,
        BEAM_BACK  = 2'd2
    } beam_t;

    typedef struct packed {
        logic                     hx;
        logic                     hy;
        logic signed [TERM_W-1:0] term;
    } lane_out_t;

    // Q14 sine of r/65536 turn, r in 0..16384
    function automatic logic [15:0] sin_quarter(input logic [14:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        res;
        logic signed [63:0] sum;
        x    = (64'(r) * 64'd6746518852) >> 16;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        if (sum < 0) begin
            sum = 0;
        end
        res = (unsigned'(sum) + 64'd32768) >> 16;
        if (res > 64'd16384) begin
            res = 64'd16384;
        end
        return res[15:0];
    endfunction

    function automatic logic signed [SC_W-1:0] sin_turn(input logic [16:0] t_in);
        logic [1:0]  quad;
        logic [14:0] r;
        logic [15:0] m;
        quad = t_in[15:14];
        r    = {1'b0, t_in[13:0]};
        if (quad[0]) begin
            r = 15'(15'd16384 - r);
        end
        m = sin_quarter(r);
        return quad[1] ? -signed'(m) : signed'(m);
    endfunction

    function automatic logic [15:0] sat16(input logic signed [21:0] v);
        if (v > 22'sd32767) begin
            return 16'h7FFF;
        end else if (v < -22'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/wall_distance_position_fix_unit.sv =====
// ----------------------------------------------------------------------------
// wall_distance_position_fix_unit
// Corrects odometry x/y from three wall distance rays on a square field.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata pose+readings, s_tuser enable mask
// m_       out  m_tvalid/m_tready  m_tdata corrected pose and hit counts
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle while no result is held; stages are the sine ROM, two lane stages and four merge
// stages including the output register.
// The seven stages advance together while the output register is empty or
// taken; a held result stalls the whole pipe and s_tready.
// aresetn clears stage valids and configuration; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_distance_position_fix_unit #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // odom_x, odom_y, heading, left_mm, right_mm, back_mm, zero pad
    input  wire logic [wdpf_pkg::IN_DATA_W-1:0]       s_tdata,
    // enable_mask
    input  wire logic [wdpf_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // new_x, new_y, heading_out, x_hits, y_hits, zero pad
    output logic [wdpf_pkg::OUT_DATA_W-1:0]           m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [wdpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [wdpf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wdpf_pkg::*;

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int N_STAGE = 7;

    logic              adv;
    logic [N_STAGE-1:0] vld_reg;
    logic [MM_W-1:0]   min_reg, max_reg;
    logic [SPAN_W-1:0] span_reg;

    logic [31:0]       idx_prod;
    logic [IDX_W-1:0]  idx;
    logic signed [SC_W-1:0] sin_q, cos_q;

    logic signed [15:0] ox_reg [3];
    logic signed [15:0] oy_reg [3];
    logic [15:0]        hd_reg [N_STAGE];
    logic [2:0]         en;
    lane_out_t          lane_q [3];

    logic [15:0] new_x, new_y;
    logic [1:0]  x_hits, y_hits;

    assign adv       = !vld_reg[N_STAGE-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign en        = s_tuser;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= MIN_VALID_RST;
            max_reg  <= MAX_VALID_RST;
            span_reg <= WALL_SPAN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_VALID: min_reg  <= cfg_data[MM_W-1:0];
                REG_MAX_VALID: max_reg  <= cfg_data[MM_W-1:0];
                REG_WALL_SPAN: span_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N_STAGE-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg[0] <= signed'(s_tdata[15:0]);
            oy_reg[0] <= signed'(s_tdata[31:16]);
            ox_reg[1] <= ox_reg[0];
            oy_reg[1] <= oy_reg[0];
            ox_reg[2] <= ox_reg[1];
            oy_reg[2] <= oy_reg[1];
            hd_reg[0] <= s_tdata[47:32];
            for (int i = 1; i < N_STAGE; i++) begin
                hd_reg[i] <= hd_reg[i-1];
            end
        end
    end

    assign idx_prod = 32'(s_tdata[47:32]) * 32'(SINE_TABLE_DEPTH);
    assign idx      = idx_prod[16 +: IDX_W];

    wdpf_sin_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk  (aclk),
        .adv   (adv),
        .idx   (idx),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    wdpf_lane #(.BEAM(BEAM_LEFT), .OFF_X(LEFT_OX), .OFF_Y(LEFT_OY)) u_lane_left (
        .aclk (aclk), .aresetn (aresetn), .adv (adv), .use_in (en[0]),
        .mm (s_tdata[61:48]), .min_mm (min_reg), .max_mm (max_reg), .span (span_reg),
        .sin_q (sin_q), .cos_q (cos_q), .lane_out (lane_q[0])
    );

    wdpf_lane #(.BEAM(BEAM_RIGHT), .OFF_X(RIGHT_OX), .OFF_Y(RIGHT_OY)) u_lane_right (
        .aclk (aclk), .aresetn (aresetn), .adv (adv), .use_in (en[1]),
        .mm (s_tdata[75:62]), .min_mm (min_reg), .max_mm (max_reg), .span (span_reg),
        .sin_q (sin_q), .cos_q (cos_q), .lane_out (lane_q[1])
    );

    wdpf_lane #(.BEAM(BEAM_BACK), .OFF_X(BACK_OX), .OFF_Y(BACK_OY)) u_lane_back (
        .aclk (aclk), .aresetn (aresetn), .adv (adv), .use_in (en[2]),
        .mm (s_tdata[89:76]), .min_mm (min_reg), .max_mm (max_reg), .span (span_reg),
        .sin_q (sin_q), .cos_q (cos_q), .lane_out (lane_q[2])
    );

    wdpf_merge u_merge (
        .aclk   (aclk),
        .adv    (adv),
        .lane0  (lane_q[0]),
        .lane1  (lane_q[1]),
        .lane2  (lane_q[2]),
        .ox     (ox_reg[2]),
        .oy     (oy_reg[2]),
        .new_x  (new_x),
        .new_y  (new_y),
        .x_hits (x_hits),
        .y_hits (y_hits)
    );

    assign m_tvalid = vld_reg[N_STAGE-1];
    assign m_tdata  = {4'b0, y_hits, x_hits, hd_reg[N_STAGE-1], new_y, new_x};

    a_hits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, x_hits} + {1'b0, y_hits}) <= 3'd3)
        else $error("more hits than rays");

    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output held");

    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item lost");

endmodule

`default_nettype wire

// ===== sv/wdpf_sin_rom.sv =====
// ----------------------------------------------------------------------------
// wdpf_sin_rom
// Sine/cosine lookup of the quantized heading, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wdpf_sin_rom #(
    parameter int DEPTH = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              adv,
    input  wire logic [$clog2(DEPTH)-1:0]          idx,
    output logic signed [wdpf_pkg::SC_W-1:0]       sin_q,
    output logic signed [wdpf_pkg::SC_W-1:0]       cos_q
);
    import wdpf_pkg::*;

    logic [2*SC_W-1:0] rom_tab [DEPTH];
    logic [2*SC_W-1:0] rd_reg;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tab
        localparam logic [16:0] T = 17'((64'(gi) << 16) / DEPTH);
        assign rom_tab[gi] = {sin_turn(17'(T + 17'd16384)), sin_turn(T)};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg <= rom_tab[idx];
        end
    end

    assign sin_q = signed'(rd_reg[SC_W-1:0]);
    assign cos_q = signed'(rd_reg[2*SC_W-1:SC_W]);

endmodule

`default_nettype wire

// ===== sv/wdpf_lane.sv =====
// ----------------------------------------------------------------------------
// wdpf_lane
// One sensor ray: range check, mm to 1/256 in, wall choice, Q14 term.
// ----------------------------------------------------------------------------
`default_nettype none

module wdpf_lane #(
    parameter wdpf_pkg::beam_t BEAM  = wdpf_pkg::BEAM_LEFT,
    parameter int              OFF_X = 0,
    parameter int              OFF_Y = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire logic                              use_in,
    input  wire logic [wdpf_pkg::MM_W-1:0]         mm,
    input  wire logic [wdpf_pkg::MM_W-1:0]         min_mm,
    input  wire logic [wdpf_pkg::MM_W-1:0]         max_mm,
    input  wire logic [wdpf_pkg::SPAN_W-1:0]       span,
    input  wire logic signed [wdpf_pkg::SC_W-1:0]  sin_q,
    input  wire logic signed [wdpf_pkg::SC_W-1:0]  cos_q,
    output wdpf_pkg::lane_out_t                    lane_out
);
    import wdpf_pkg::*;

    // stage 1
    logic        ok1_reg, ok1_next;
    logic [25:0] num;
    logic [50:0] recip_reg, recip_next;

    // stage 2
    logic [17:0]        d;
    logic signed [16:0] ux, uy, ax, ay;
    logic               ok2_reg, sel_x_reg, pos_x_reg, pos_y_reg, uy_nz_reg;
    logic signed [29:0] offx_reg, offx_next, offy_reg, offy_next;
    logic signed [TERM_W-1:0] udx_reg, udx_next, udy_reg, udy_next;

    // stage 3
    logic signed [TERM_W-1:0] span_q, term_next;
    logic                     hx_reg, hy_reg;
    logic signed [TERM_W-1:0] term_reg;

    assign ok1_next   = use_in && (mm >= min_mm) && (mm <= max_mm);
    assign num        = 26'(mm) * 26'd2560 + 26'd127;
    assign recip_next = 51'(num[25:1]) * 51'(RECIP_127);

    assign d = recip_reg[49:32];

    always_comb begin
        case (BEAM)
            BEAM_LEFT: begin
                ux = -17'(cos_q);
                uy = 17'(sin_q);
            end
            BEAM_RIGHT: begin
                ux = 17'(cos_q);
                uy = -17'(sin_q);
            end
            BEAM_BACK: begin
                ux = -17'(sin_q);
                uy = -17'(cos_q);
            end
            default: begin
                ux = '0;
                uy = '0;
            end
        endcase
        ax = (ux < 0) ? -ux : ux;
        ay = (uy < 0) ? -uy : uy;
    end

    assign offx_next = 30'(OFF_X * cos_q + OFF_Y * sin_q);
    assign offy_next = 30'(OFF_Y * cos_q - OFF_X * sin_q);
    assign udx_next  = TERM_W'(ux) * TERM_W'(signed'({1'b0, d}));
    assign udy_next  = TERM_W'(uy) * TERM_W'(signed'({1'b0, d}));

    assign span_q = TERM_W'(signed'({1'b0, span, 14'b0}));

    always_comb begin
        if (sel_x_reg) begin
            term_next = (pos_x_reg ? span_q : -span_q) - TERM_W'(offx_reg) - udx_reg;
        end else begin
            term_next = (pos_y_reg ? span_q : -span_q) - TERM_W'(offy_reg) - udy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok1_reg <= 1'b0;
            ok2_reg <= 1'b0;
            hx_reg  <= 1'b0;
            hy_reg  <= 1'b0;
        end else if (adv) begin
            ok1_reg <= ok1_next;
            ok2_reg <= ok1_reg;
            hx_reg  <= ok2_reg && sel_x_reg;
            hy_reg  <= ok2_reg && !sel_x_reg && uy_nz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            recip_reg <= recip_next;
            sel_x_reg <= ax > ay;
            pos_x_reg <= ux > 0;
            pos_y_reg <= uy > 0;
            uy_nz_reg <= uy != 0;
            offx_reg  <= offx_next;
            offy_reg  <= offy_next;
            udx_reg   <= udx_next;
            udy_reg   <= udy_next;
            term_reg  <= term_next;
        end
    end

    assign lane_out = '{hx: hx_reg, hy: hy_reg, term: term_reg};

    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hx_reg && hy_reg))
        else $error("ray fixed both axes");

    a_hit_needs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !ok2_reg |=> !hx_reg && !hy_reg)
        else $error("hit without valid reading");

    a_hit_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && ok2_reg && sel_x_reg |=> hx_reg)
        else $error("side-wall ray lost");

endmodule

`default_nettype wire

// ===== sv/wdpf_merge.sv =====
// ----------------------------------------------------------------------------
// wdpf_merge
// Sums lane terms per axis, rounds the mean (odometry where an axis has no hit), saturates to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wdpf_merge (
    input  wire logic                   aclk,
    input  wire logic                   adv,
    input  wire wdpf_pkg::lane_out_t    lane0,
    input  wire wdpf_pkg::lane_out_t    lane1,
    input  wire wdpf_pkg::lane_out_t    lane2,
    input  wire logic signed [15:0]     ox,
    input  wire logic signed [15:0]     oy,
    output logic [15:0]                 new_x,
    output logic [15:0]                 new_y,
    output logic [1:0]                  x_hits,
    output logic [1:0]                  y_hits
);
    import wdpf_pkg::*;

    // stage 4: sums
    logic signed [TERM_W-1:0] xs_reg, ys_reg, xs_next, ys_next;
    logic [1:0]               xn4_reg, yn4_reg, xn_next, yn_next;
    logic signed [15:0]       ox4_reg, oy4_reg;

    // stage 5: rounded /16384
    logic signed [TERM_W-1:0] xr, yr;
    logic signed [21:0]       vx5_reg, vy5_reg;
    logic [1:0]               xn5_reg, yn5_reg;
    logic signed [15:0]       ox5_reg, oy5_reg;

    // stage 6: /3 product
    logic [22:0]        wx, wy;
    logic [45:0]        px_reg, py_reg;
    logic signed [21:0] vx6_reg, vy6_reg;
    logic [1:0]         xn6_reg, yn6_reg;
    logic signed [15:0] ox6_reg, oy6_reg;

    // stage 7: output
    logic signed [21:0] qx, qy, rx, ry;
    logic [15:0]        nx_reg, ny_reg;
    logic [1:0]         xh_reg, yh_reg;

    assign xs_next = (lane0.hx ? lane0.term : '0) + (lane1.hx ? lane1.term : '0)
                   + (lane2.hx ? lane2.term : '0);
    assign ys_next = (lane0.hy ? lane0.term : '0) + (lane1.hy ? lane1.term : '0)
                   + (lane2.hy ? lane2.term : '0);
    assign xn_next = 2'(lane0.hx) + 2'(lane1.hx) + 2'(lane2.hx);
    assign yn_next = 2'(lane0.hy) + 2'(lane1.hy) + 2'(lane2.hy);

    assign xr = xs_reg + signed'(TERM_W'(xn4_reg) << 13);
    assign yr = ys_reg + signed'(TERM_W'(yn4_reg) << 13);

    assign wx = 23'(24'(vx5_reg) + 24'(DIV3_BIAS));
    assign wy = 23'(24'(vy5_reg) + 24'(DIV3_BIAS));

    assign qx = signed'(22'(px_reg[45:24])) - 22'sd1048576;
    assign qy = signed'(22'(py_reg[45:24])) - 22'sd1048576;

    always_comb begin
        case (xn6_reg)
            2'd0:    rx = 22'(ox6_reg);
            2'd1:    rx = vx6_reg;
            2'd2:    rx = vx6_reg >>> 1;
            default: rx = qx;
        endcase
        case (yn6_reg)
            2'd0:    ry = 22'(oy6_reg);
            2'd1:    ry = vy6_reg;
            2'd2:    ry = vy6_reg >>> 1;
            default: ry = qy;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xs_reg  <= xs_next;
            ys_reg  <= ys_next;
            xn4_reg <= xn_next;
            yn4_reg <= yn_next;
            ox4_reg <= ox;
            oy4_reg <= oy;

            vx5_reg <= xr[TERM_W-1:14];
            vy5_reg <= yr[TERM_W-1:14];
            xn5_reg <= xn4_reg;
            yn5_reg <= yn4_reg;
            ox5_reg <= ox4_reg;
            oy5_reg <= oy4_reg;

            px_reg  <= 46'(wx) * 46'(RECIP_3);
            py_reg  <= 46'(wy) * 46'(RECIP_3);
            vx6_reg <= vx5_reg;
            vy6_reg <= vy5_reg;
            xn6_reg <= xn5_reg;
            yn6_reg <= yn5_reg;
            ox6_reg <= ox5_reg;
            oy6_reg <= oy5_reg;

            nx_reg  <= sat16(rx);
            ny_reg  <= sat16(ry);
            xh_reg  <= xn6_reg;
            yh_reg  <= yn6_reg;
        end
    end

    assign new_x  = nx_reg;
    assign new_y  = ny_reg;
    assign x_hits = xh_reg;
    assign y_hits = yh_reg;

endmodule

`default_nettype wire
